// ----- rtl/dbm_pkg.sv -----
// Shared types, widths and register codes of the directional Butterworth mask.
`default_nettype none

package dbm_pkg;

  // Largest image dimension handled; sizes and indices clamp against it.
  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned OutBitsDef = 16;
  localparam int unsigned MaxOrder   = 4;

  // APB register file
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegImageWidth  = 3'd0;
  localparam logic [RegIdxW-1:0] RegImageHeight = 3'd1;
  localparam logic [RegIdxW-1:0] RegFilterOrder = 3'd2;
  localparam logic [RegIdxW-1:0] RegCosTheta    = 3'd3;
  localparam logic [RegIdxW-1:0] RegSinTheta    = 3'd4;
  localparam logic [RegIdxW-1:0] RegInvRadius   = 3'd5;

  // Field widths
  localparam int unsigned PixW  = 12;
  localparam int unsigned DimW  = 13;
  localparam int unsigned OrdW  = 3;
  localparam int unsigned TrigW = 16;
  localparam int unsigned InvW  = 24;

  localparam logic [DimW-1:0]  ImageWidthRst  = 13'd256;
  localparam logic [DimW-1:0]  ImageHeightRst = 13'd256;
  localparam logic [OrdW-1:0]  FilterOrderRst = 3'd1;
  localparam logic [TrigW-1:0] CosThetaRst    = 16'd32767;
  localparam logic [TrigW-1:0] SinThetaRst    = 16'd0;
  localparam logic [InvW-1:0]  InvRadiusRst   = 24'd65536;

  // Datapath widths
  localparam int unsigned DxW      = 15;  // doubled offset, signed
  localparam int unsigned PrjW     = 31;  // projection, signed
  localparam int unsigned MagW     = 30;  // projection magnitude
  localparam int unsigned UpW      = 54;  // magnitude times inverse radius
  localparam int unsigned UShift   = 6;   // align to Q.32
  localparam int unsigned PowW     = 62;  // Q.32 power term, saturates at 2^62
  localparam int unsigned PowHalfW = 31;
  localparam int unsigned FracW    = 32;
  localparam int unsigned SumW     = 63;  // 1 + w in Q.32

  localparam logic [PowW-1:0] PowOne     = PowW'(1) << FracW;
  localparam logic [SumW-1:0] SumOne     = SumW'(1) << FracW;
  // Remainder after the leading numerator bits of 2^(2*OUT_BITS+32) are consumed
  localparam logic [SumW-1:0] DivRemInit = SumW'(1) << (FracW - 1);

  typedef struct packed {
    logic [DimW-1:0]  image_width;
    logic [DimW-1:0]  image_height;
    logic [OrdW-1:0]  filter_order;
    logic [TrigW-1:0] cos_theta;
    logic [TrigW-1:0] sin_theta;
    logic [InvW-1:0]  inv_radius;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/directional_butterworth_mask.sv -----
// Directional Butterworth mask: per pixel gain 1/sqrt(1 + u^(2n)), u the scaled projection.
// Pipeline depth grows with the one-bit-per-stage divider and square root pipelines.
// Throughput: one pixel per cycle while the output buffer is not full; a two-entry output
// buffer keeps input ready while a result waits. Reset clears all valid bits and loads the
// register defaults; no clearing pass.
`default_nettype none

module directional_butterworth_mask #(
  parameter int unsigned OUT_BITS = dbm_pkg::OutBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbm_pkg::PaddrW-1:0]  paddr,
  input  logic [dbm_pkg::DataW-1:0]   pwdata,
  output logic [dbm_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dbm_pkg::PixW-1:0]    pixel_column_i,
  input  logic [dbm_pkg::PixW-1:0]    pixel_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [OUT_BITS-1:0]         mask_value_o
);
  import dbm_pkg::*;

  localparam int unsigned ClampW = 17;

  cfg_t cfg;

  dbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline advances unless the output buffer is full
  logic en;
  logic skid_vld_q, skid_vld_d, out_vld_q, out_vld_d;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // Stage 1: clamp and doubled centre offsets
  logic [PixW-1:0]      col_c, row_c;
  logic [DimW-1:0]      wid_c, hgt_c;
  logic signed [DxW-1:0] dx2_q, dy2_q;
  logic                 vld1_q, vld2_q, vld3_q, vld4_q, vld_s_q;

  assign col_c = (ClampW'(pixel_column_i) > ClampW'(MaxDim - 1)) ? PixW'(MaxDim - 1)
                                                                   : pixel_column_i;
  assign row_c = (ClampW'(pixel_row_i) > ClampW'(MaxDim - 1)) ? PixW'(MaxDim - 1)
                                                                : pixel_row_i;
  assign wid_c = (ClampW'(cfg.image_width) > ClampW'(MaxDim)) ? DimW'(MaxDim)
                                                               : cfg.image_width;
  assign hgt_c = (ClampW'(cfg.image_height) > ClampW'(MaxDim)) ? DimW'(MaxDim)
                                                                : cfg.image_height;

  // Stage 2: rotate; stage 3: magnitude; stage 4: scale by inverse radius
  logic signed [PrjW-1:0] px_q, py_q, prj;
  logic [MagW-1:0]        mag_q;
  logic [UpW-1:0]         up_q;

  assign prj = px_q - py_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx2_q <= $signed({2'b00, col_c, 1'b0}) - $signed({2'b00, wid_c});
      dy2_q <= $signed({2'b00, row_c, 1'b0}) - $signed({2'b00, hgt_c});
      px_q  <= PrjW'(dx2_q) * PrjW'($signed(cfg.cos_theta));
      py_q  <= PrjW'(dy2_q) * PrjW'($signed(cfg.sin_theta));
      mag_q <= MagW'(prj[PrjW-1] ? -prj : prj);
      up_q  <= UpW'(mag_q) * UpW'(cfg.inv_radius);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // Power chain: t = u^2, then w = w*t up to three times.
  // Steps beyond the order multiply by one, which passes w through unchanged.
  logic [OrdW-1:0] order_eff;
  logic            act1, act2, act3;
  logic [PowW-1:0] uq, t0, t1, t2, prod1, prod2, prod3;
  logic            v0, v1, v2, v3, ovf0, ovf1, ovf2, ovf3, sat1, sat2, sat3;
  logic [PowW+1:0] side1, side2;
  logic [1:0]      side3;

  assign order_eff = (cfg.filter_order == '0) ? OrdW'(1) :
                     (cfg.filter_order > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : cfg.filter_order;
  assign act1 = order_eff > OrdW'(1);
  assign act2 = order_eff > OrdW'(2);
  assign act3 = order_eff > OrdW'(3);

  assign uq = PowW'(up_q[UpW-1:UShift]);

  dbm_qmul #(.SIDE_W(1)) u_pow0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (uq),
    .b_i    (uq),
    .side_i (vld4_q),
    .prod_o (t0),
    .ovf_o  (ovf0),
    .side_o (v0)
  );

  dbm_qmul #(.SIDE_W(PowW + 2)) u_pow1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (t0),
    .b_i    (act1 ? t0 : PowOne),
    .side_i ({v0, ovf0, t0}),
    .prod_o (prod1),
    .ovf_o  (ovf1),
    .side_o (side1)
  );

  assign v1   = side1[PowW+1];
  assign sat1 = side1[PowW] | ovf1;
  assign t1   = side1[PowW-1:0];

  dbm_qmul #(.SIDE_W(PowW + 2)) u_pow2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (prod1),
    .b_i    (act2 ? t1 : PowOne),
    .side_i ({v1, sat1, t1}),
    .prod_o (prod2),
    .ovf_o  (ovf2),
    .side_o (side2)
  );

  assign v2   = side2[PowW+1];
  assign sat2 = side2[PowW] | ovf2;
  assign t2   = side2[PowW-1:0];

  dbm_qmul #(.SIDE_W(2)) u_pow3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (prod2),
    .b_i    (act3 ? t2 : PowOne),
    .side_i ({v2, sat2}),
    .prod_o (prod3),
    .ovf_o  (ovf3),
    .side_o (side3)
  );

  assign v3   = side3[1];
  assign sat3 = side3[0] | ovf3;

  // s = 1 + w
  logic [SumW-1:0] sum_q;
  logic            kill_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q    <= SumW'(prod3) + SumOne;
      kill_s_q <= sat3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q <= 1'b0;
    end else if (en) begin
      vld_s_q <= v3;
    end
  end

  // gain = isqrt(floor(2^(2*OUT_BITS+32) / s))
  logic                vld_q_div, kill_q_div, vld_r, kill_r;
  logic [2*OUT_BITS:0] quo;
  logic [OUT_BITS:0]   root;

  dbm_div #(.OUT_BITS(OUT_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_s_q),
    .kill_i (kill_s_q),
    .den_i  (sum_q),
    .vld_o  (vld_q_div),
    .kill_o (kill_q_div),
    .quo_o  (quo)
  );

  dbm_isqrt #(.OUT_BITS(OUT_BITS)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_q_div),
    .kill_i (kill_q_div),
    .rad_i  (quo),
    .vld_o  (vld_r),
    .kill_o (kill_r),
    .root_o (root)
  );

  // Saturate unity gain, drop to zero on power overflow
  logic [OUT_BITS-1:0] mask_nx, out_data_q, skid_data_q;
  logic                push, head_free;

  assign mask_nx = kill_r ? '0 : (root[OUT_BITS] ? '1 : root[OUT_BITS-1:0]);
  assign push      = en & vld_r;
  assign head_free = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (head_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = push;
      end
    end else if (push) begin
      // hold the head, park the new result
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_free) begin
      out_data_q <= skid_vld_q ? skid_data_q : mask_nx;
    end
    if (!head_free && push) begin
      skid_data_q <= mask_nx;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign mask_value_o = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/dbm_regs.sv -----
// APB configuration register file of the directional Butterworth mask.
`default_nettype none

module dbm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbm_pkg::PaddrW-1:0]  paddr,
  input  logic [dbm_pkg::DataW-1:0]   pwdata,
  output logic [dbm_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output dbm_pkg::cfg_t               cfg_o
);
  import dbm_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[PaddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegImageWidth:  cfg_d.image_width  = pwdata[DimW-1:0];
        RegImageHeight: cfg_d.image_height = pwdata[DimW-1:0];
        RegFilterOrder: cfg_d.filter_order = pwdata[OrdW-1:0];
        RegCosTheta:    cfg_d.cos_theta    = pwdata[TrigW-1:0];
        RegSinTheta:    cfg_d.sin_theta    = pwdata[TrigW-1:0];
        RegInvRadius:   cfg_d.inv_radius   = pwdata[InvW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegImageWidth:  prdata = DataW'(cfg_q.image_width);
      RegImageHeight: prdata = DataW'(cfg_q.image_height);
      RegFilterOrder: prdata = DataW'(cfg_q.filter_order);
      RegCosTheta:    prdata = DataW'(cfg_q.cos_theta);
      RegSinTheta:    prdata = DataW'(cfg_q.sin_theta);
      RegInvRadius:   prdata = DataW'(cfg_q.inv_radius);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= ImageWidthRst;
      cfg_q.image_height <= ImageHeightRst;
      cfg_q.filter_order <= FilterOrderRst;
      cfg_q.cos_theta    <= CosThetaRst;
      cfg_q.sin_theta    <= SinThetaRst;
      cfg_q.inv_radius   <= InvRadiusRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/dbm_qmul.sv -----
// Two-stage Q.32 multiplier: four registered partial products, then sum and overflow check.
`default_nettype none

module dbm_qmul #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [dbm_pkg::PowW-1:0]   a_i,
  input  logic [dbm_pkg::PowW-1:0]   b_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic [dbm_pkg::PowW-1:0]   prod_o,
  output logic                       ovf_o,
  output logic [SIDE_W-1:0]          side_o
);
  import dbm_pkg::*;

  localparam int unsigned FullW = 2 * PowW;

  logic [PowW-1:0]   p00_q, p01_q, p10_q, p11_q;
  logic [SIDE_W-1:0] side_a_q, side_b_q;
  logic [FullW-1:0]  full;
  logic [PowW-1:0]   prod_q;
  logic              ovf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= PowW'(a_i[PowHalfW-1:0]) * PowW'(b_i[PowHalfW-1:0]);
      p01_q <= PowW'(a_i[PowHalfW-1:0]) * PowW'(b_i[PowW-1:PowHalfW]);
      p10_q <= PowW'(a_i[PowW-1:PowHalfW]) * PowW'(b_i[PowHalfW-1:0]);
      p11_q <= PowW'(a_i[PowW-1:PowHalfW]) * PowW'(b_i[PowW-1:PowHalfW]);
    end
  end

  assign full = (FullW'(p11_q) << PowW) + (FullW'(p01_q) << PowHalfW)
              + (FullW'(p10_q) << PowHalfW) + FullW'(p00_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[PowW+FracW-1:FracW];
      // product reaches 2^62 in Q.32
      ovf_q  <= |full[FullW-1:PowW+FracW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q <= '0;
      side_b_q <= '0;
    end else if (en_i) begin
      side_a_q <= side_i;
      side_b_q <= side_a_q;
    end
  end

  assign prod_o = prod_q;
  assign ovf_o  = ovf_q;
  assign side_o = side_b_q;

endmodule

`default_nettype wire

// ----- rtl/dbm_div.sv -----
// Restoring divider pipeline, one quotient bit per stage: quo = floor(2^(2*OUT_BITS+32) / den).
`default_nettype none

module dbm_div #(
  parameter int unsigned OUT_BITS = dbm_pkg::OutBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic                      kill_i,
  input  logic [dbm_pkg::SumW-1:0]  den_i,
  output logic                      vld_o,
  output logic                      kill_o,
  output logic [2*OUT_BITS:0]       quo_o
);
  import dbm_pkg::*;

  localparam int unsigned QuoW = 2 * OUT_BITS + 1;

  logic            vld_q  [QuoW];
  logic            kill_q [QuoW];
  logic [SumW-1:0] rem_q  [QuoW];
  logic [SumW-1:0] den_q  [QuoW];
  logic [QuoW-1:0] quo_q  [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_step
    logic            vld_in, kill_in, take;
    logic [SumW-1:0] rem_in, den_in;
    logic [QuoW-1:0] quo_in, quo_nx;
    logic [SumW:0]   trial, diff;

    if (i == 0) begin : g_head
      assign vld_in  = vld_i;
      assign kill_in = kill_i;
      assign rem_in  = DivRemInit;
      assign den_in  = den_i;
      assign quo_in  = '0;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign kill_in = kill_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign quo_in  = quo_q[i-1];
    end

    // numerator bits below the leading one are zero: shift in zero
    assign trial = {rem_in, 1'b0};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_comb begin
      quo_nx = quo_in;
      quo_nx[QuoW-1-i] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        kill_q[i] <= kill_in;
        den_q[i]  <= den_in;
        rem_q[i]  <= take ? diff[SumW-1:0] : trial[SumW-1:0];
        quo_q[i]  <= quo_nx;
      end
    end
  end

  assign vld_o  = vld_q[QuoW-1];
  assign kill_o = kill_q[QuoW-1];
  assign quo_o  = quo_q[QuoW-1];

endmodule

`default_nettype wire

// ----- rtl/dbm_isqrt.sv -----
// Integer square root pipeline, one root bit per stage, remainder kept incrementally.
`default_nettype none

module dbm_isqrt #(
  parameter int unsigned OUT_BITS = dbm_pkg::OutBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic                 kill_i,
  input  logic [2*OUT_BITS:0]  rad_i,
  output logic                 vld_o,
  output logic                 kill_o,
  output logic [OUT_BITS:0]    root_o
);
  localparam int unsigned RadW  = 2 * OUT_BITS + 1;
  localparam int unsigned TrW   = RadW + 1;
  localparam int unsigned RootW = OUT_BITS + 1;

  logic             vld_q  [RootW];
  logic             kill_q [RootW];
  logic [RadW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_step
    localparam int unsigned Bit = OUT_BITS - i;

    logic             vld_in, kill_in, take;
    logic [RadW-1:0]  rem_in;
    logic [RootW-1:0] root_in, root_nx;
    logic [TrW-1:0]   trial, diff;

    if (i == 0) begin : g_head
      assign vld_in  = vld_i;
      assign kill_in = kill_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign kill_in = kill_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = (TrW'(root_in) << (Bit + 1)) + (TrW'(1) << (2 * Bit));
    assign diff  = {1'b0, rem_in} - trial;
    assign take  = {1'b0, rem_in} >= trial;

    always_comb begin
      root_nx = root_in;
      root_nx[Bit] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        kill_q[i] <= kill_in;
        rem_q[i]  <= take ? diff[RadW-1:0] : rem_in;
        root_q[i] <= root_nx;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign kill_o = kill_q[RootW-1];
  assign root_o = root_q[RootW-1];

endmodule

`default_nettype wire
